/* rtl/core/llx_pkg.sv */
// Shared types and constants of the light-sensor lux estimator.
// Holds the sequencer states, divider handshake structs and fixed-point constants.
// No dependencies.
package llx_pkg;

  localparam int DIV_W = 32;   // dividend and quotient width of the shared divider
  localparam int DVS_W = 16;   // divisor width of the shared divider
  localparam int MUL_W = 34;   // signed operand width of the shared multiplier
  localparam int E_W   = 44;   // signed width of the base-2 exponent in Q.32
  localparam int FS_W  = 16;   // full-scale and log argument width
  localparam int FRAC_W = 20;  // fraction bits of the log2 result
  localparam int LOG_W = 24;   // log2 result, 4 integer and 20 fraction bits

  localparam logic [4:0] LOG_LAST_STEP = 5'd19;
  localparam logic [3:0] EXP_LAST_TERM = 4'd12;

  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [31:0] LN2_Q32   = 32'd2977044471;

  localparam logic [2:0] REG_FULL_SCALE   = 3'd0;
  localparam logic [2:0] REG_MODEL_WEIGHT = 3'd1;
  localparam logic [2:0] REG_MODEL_BIAS   = 3'd2;
  localparam logic [2:0] REG_DIM_LIMIT    = 3'd3;
  localparam logic [2:0] REG_COZY_LIMIT   = 3'd4;
  localparam logic [2:0] REG_BRIGHT_LIMIT = 3'd5;

  localparam logic [1:0] CLASS_DARK       = 2'd0;
  localparam logic [1:0] CLASS_COZY       = 2'd1;
  localparam logic [1:0] CLASS_FUNCTIONAL = 2'd2;
  localparam logic [1:0] CLASS_INTENSE    = 2'd3;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_AVG_GO,
    ST_AVG_WAIT,
    ST_PCT_GO,
    ST_PCT_WAIT,
    ST_LOG_INIT,
    ST_LOG_MUL,
    ST_LOG_UPD,
    ST_E_MUL1,
    ST_E_MUL2,
    ST_E_SUM,
    ST_Y_MUL,
    ST_Y_GET,
    ST_T_MUL,
    ST_T_DIV,
    ST_T_WAIT,
    ST_SHIFT,
    ST_FINISH
  } llx_state_e;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } llx_div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } llx_div_rsp_t;

endpackage

/* rtl/core/ldr_lux_estimator.sv */
// Top level of the light-sensor lux estimator: sample averaging and the lux sequencer.
// Depends on llx_pkg and on the shared divider llx_div.
//
// Samples are summed one per transfer, and a sample that does not complete a block
// leaves the estimator ready for the next one. The sample that completes a block of
// SAMPLES_PER_AVERAGE starts the result sequence, during which no sample is taken;
// its length is set mostly by the shared one-bit-per-cycle divider (the percent and
// twelve Taylor-term divisions) plus two 20-step log2 squaring loops on the shared
// multiplier. The average itself is a reciprocal multiplication on the shared
// multiplier. A zero average or a saturating exponent ends the sequence early. A
// finished result sits in the output register until its transfer, so new samples are
// accepted meanwhile; the sequence only waits at its last step if the previous
// result has not yet been taken.
module ldr_lux_estimator import llx_pkg::*; #(
  parameter int SAMPLES_PER_AVERAGE = 8,
  parameter int SAMPLE_BITS         = 12
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [SAMPLE_BITS-1:0] adc_sample_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [SAMPLE_BITS-1:0] average_raw_o,
  output logic [9:0]             percent_tenths_o,
  output logic [31:0]            lux_estimate_o,
  output logic                   lux_saturated_o,
  output logic [1:0]             light_class_o,
  input  logic                   cfg_we_i,
  input  logic [2:0]             cfg_index_i,
  input  logic [31:0]            cfg_data_i
);

  localparam int CNT_W = $clog2(SAMPLES_PER_AVERAGE);
  localparam int SUM_W = SAMPLE_BITS + CNT_W;

  // The average is floor(sum * AVG_RECIP / 2^AVG_SHIFT), which is exact for every
  // sum below 2^SUM_W because the reciprocal is rounded up.
  localparam int     AVG_SHIFT = SUM_W + CNT_W;
  localparam longint AVG_RECIP = ((longint'(1) <<< AVG_SHIFT) + SAMPLES_PER_AVERAGE - 1)
                                 / SAMPLES_PER_AVERAGE;

  // Configuration registers.
  logic [15:0]        full_scale_q;
  logic signed [15:0] weight_q;
  logic signed [23:0] bias_q;
  logic [31:0]        dim_q, cozy_q, bright_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_scale_q <= 16'd4095;
      weight_q     <= 16'sd4096;
      bias_q       <= '0;
      dim_q        <= 32'd12800;
      cozy_q       <= 32'd38400;
      bright_q     <= 32'd128000;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_FULL_SCALE:   full_scale_q <= cfg_data_i[15:0];
        REG_MODEL_WEIGHT: weight_q     <= signed'(cfg_data_i[15:0]);
        REG_MODEL_BIAS:   bias_q       <= signed'(cfg_data_i[23:0]);
        REG_DIM_LIMIT:    dim_q        <= cfg_data_i;
        REG_COZY_LIMIT:   cozy_q       <= cfg_data_i;
        REG_BRIGHT_LIMIT: bright_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Full scale values below two behave as two.
  logic [15:0] fs_eff;
  assign fs_eff = (full_scale_q < 16'd2) ? 16'd2 : full_scale_q;

  llx_state_e state_q, state_d;

  // Accumulator and working registers.
  logic [SUM_W-1:0]       sum_q;
  logic [CNT_W-1:0]       cnt_q;
  logic [SAMPLE_BITS-1:0] avg_q;
  logic [9:0]             pct_q;
  logic [FS_W-1:0]        r_q;
  logic                   log_sel_q;
  logic [3:0]             lk_q;
  logic [FRAC_W-1:0]      frac_q;
  logic [4:0]             lstep_q;
  logic [31:0]            m_q;
  logic [LOG_W-1:0]       la_q, lb_q;
  logic signed [E_W-1:0]  e_q;
  logic signed [11:0]     n_q;
  logic [31:0]            f_q, y_q;
  logic [32:0]            term_q;
  logic [33:0]            esum_q;
  logic [3:0]             k_q;
  logic [31:0]            lux_q;
  logic                   sat_q;
  logic signed [2*MUL_W-1:0] prod_q;

  // Output register.
  logic                   out_valid_q;
  logic [SAMPLE_BITS-1:0] out_avg_q;
  logic [9:0]             out_pct_q;
  logic [31:0]            out_lux_q;
  logic                   out_sat_q;
  logic [1:0]             out_cls_q;

  logic in_fire, last_sample, out_free;
  assign in_fire     = in_valid_i && in_ready_o;
  assign last_sample = cnt_q == CNT_W'(SAMPLES_PER_AVERAGE - 1);
  assign out_free    = !out_valid_q || out_ready_i;

  // Shared divider.
  llx_div_req_t div_req;
  llx_div_rsp_t div_rsp;

  llx_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Derived datapath values.
  logic [FS_W-1:0]       avg16;
  logic [31:0]           avg_x1000;
  logic [FS_W-1:0]       r_next;
  logic [FS_W-1:0]       log_x;
  logic [3:0]            log_msb;
  logic [31:0]           msq;
  logic [FRAC_W-1:0]     frac_next;
  logic signed [LOG_W:0] lr;
  logic signed [E_W-1:0] bias_term, t_val;
  logic signed [11:0]    n_next;
  logic [11:0]           n_neg;
  logic [63:0]           esum_wide;
  logic [31:0]           lux_shift;
  logic [1:0]            cls;

  always_comb begin
    avg16     = FS_W'(avg_q);
    avg_x1000 = (32'(avg16) << 10) - (32'(avg16) << 5) + (32'(avg16) << 3);
    r_next    = (avg16 > fs_eff - 16'd1) ? fs_eff - 16'd1 : avg16;
    log_x     = log_sel_q ? r_q : fs_eff - r_q;
    log_msb   = '0;
    for (int i = 0; i < FS_W; i++) begin
      if (log_x[i]) log_msb = 4'(i);
    end
    // One squaring step of the normalized mantissa.
    msq       = prod_q[61:30];
    frac_next = {frac_q[FRAC_W-2:0], msq[31]};
    lr        = signed'({1'b0, la_q}) - signed'({1'b0, lb_q});
    bias_term = E_W'(prod_q >>> 14);
    t_val     = e_q + bias_term + (E_W'(1) <<< 35);
    n_next    = t_val[E_W-1:32];
    n_neg     = 12'(-n_q);
    esum_wide = 64'(esum_q);
    if (!n_q[11]) begin
      lux_shift = 32'((esum_wide << n_q[4:0]) >> 32);
    end else if (n_neg > 12'd31) begin
      lux_shift = '0;
    end else begin
      lux_shift = 32'(esum_wide >> (6'd32 + n_neg[5:0]));
    end
    if (lux_q < dim_q) cls = CLASS_DARK;
    else if (lux_q < cozy_q) cls = CLASS_COZY;
    else if (lux_q < bright_q) cls = CLASS_FUNCTIONAL;
    else cls = CLASS_INTENSE;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (in_fire && last_sample) state_d = ST_AVG_GO;
      ST_AVG_GO:   state_d = ST_AVG_WAIT;
      ST_AVG_WAIT: state_d = ST_PCT_GO;
      ST_PCT_GO:   state_d = ST_PCT_WAIT;
      ST_PCT_WAIT: begin
        if (div_rsp.done) state_d = (r_q == '0) ? ST_FINISH : ST_LOG_INIT;
      end
      ST_LOG_INIT: state_d = ST_LOG_MUL;
      ST_LOG_MUL:  state_d = ST_LOG_UPD;
      ST_LOG_UPD: begin
        if (lstep_q != LOG_LAST_STEP) state_d = ST_LOG_MUL;
        else if (!log_sel_q) state_d = ST_LOG_INIT;
        else state_d = ST_E_MUL1;
      end
      ST_E_MUL1:   state_d = ST_E_MUL2;
      ST_E_MUL2:   state_d = ST_E_SUM;
      ST_E_SUM:    state_d = (n_next >= 12'sd32) ? ST_FINISH : ST_Y_MUL;
      ST_Y_MUL:    state_d = ST_Y_GET;
      ST_Y_GET:    state_d = ST_T_MUL;
      ST_T_MUL:    state_d = ST_T_DIV;
      ST_T_DIV:    state_d = ST_T_WAIT;
      ST_T_WAIT: begin
        if (div_rsp.done) state_d = (k_q == EXP_LAST_TERM) ? ST_SHIFT : ST_T_MUL;
      end
      ST_SHIFT:    state_d = ST_FINISH;
      ST_FINISH:   if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake, divider request and multiplier operands.
  logic signed [MUL_W-1:0] mul_a, mul_b;

  always_comb begin
    in_ready_o       = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = 16'd1;
    mul_a            = '0;
    mul_b            = '0;
    case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_AVG_GO: begin
        mul_a = signed'(MUL_W'(sum_q));
        mul_b = MUL_W'(AVG_RECIP);
      end
      ST_PCT_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = avg_x1000;
        div_req.divisor  = fs_eff;
      end
      ST_LOG_MUL: begin
        mul_a = signed'({2'b0, m_q});
        mul_b = signed'({2'b0, m_q});
      end
      ST_E_MUL1: begin
        mul_a = MUL_W'(weight_q);
        mul_b = MUL_W'(lr);
      end
      ST_E_MUL2: begin
        mul_a = MUL_W'(bias_q);
        mul_b = signed'({3'b0, LOG2E_Q30});
      end
      ST_Y_MUL: begin
        mul_a = signed'({2'b0, f_q});
        mul_b = signed'({2'b0, LN2_Q32});
      end
      ST_T_MUL: begin
        mul_a = signed'({1'b0, term_q});
        mul_b = signed'({2'b0, y_q});
      end
      ST_T_DIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = prod_q[63:32];
        div_req.divisor  = DVS_W'(k_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sum_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_fire) begin
        sum_q <= sum_q + SUM_W'(adc_sample_i);
        cnt_q <= last_sample ? '0 : cnt_q + CNT_W'(1);
      end else if (state_q == ST_AVG_GO) begin
        sum_q <= '0;
      end
      if (state_q == ST_FINISH && out_free) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_AVG_WAIT: avg_q <= SAMPLE_BITS'(prod_q >>> AVG_SHIFT);
      ST_PCT_GO: begin
        r_q       <= r_next;
        log_sel_q <= 1'b0;
      end
      ST_PCT_WAIT: begin
        if (div_rsp.done) begin
          pct_q <= (div_rsp.quotient > 32'd1000) ? 10'd1000 : div_rsp.quotient[9:0];
          // A zero reading gives full scale for a positive exponent and zero otherwise.
          sat_q <= weight_q > 16'sd0;
          lux_q <= (weight_q > 16'sd0) ? 32'hFFFF_FFFF : 32'd0;
        end
      end
      ST_LOG_INIT: begin
        lk_q    <= log_msb;
        frac_q  <= '0;
        lstep_q <= '0;
        m_q     <= 32'({16'h0, log_x} << (5'd30 - {1'b0, log_msb}));
      end
      ST_LOG_UPD: begin
        frac_q  <= frac_next;
        lstep_q <= lstep_q + 5'd1;
        m_q     <= msq[31] ? {1'b0, msq[31:1]} : msq;
        if (lstep_q == LOG_LAST_STEP) begin
          log_sel_q <= 1'b1;
          if (!log_sel_q) la_q <= {lk_q, frac_next};
          else lb_q <= {lk_q, frac_next};
        end
      end
      ST_E_MUL2: e_q <= prod_q[E_W-1:0];
      ST_E_SUM: begin
        n_q   <= n_next;
        f_q   <= t_val[31:0];
        sat_q <= n_next >= 12'sd32;
        lux_q <= 32'hFFFF_FFFF;
      end
      ST_Y_GET: begin
        y_q    <= prod_q[63:32];
        term_q <= 33'h1_0000_0000;
        esum_q <= 34'h1_0000_0000;
        k_q    <= 4'd1;
      end
      ST_T_WAIT: begin
        if (div_rsp.done) begin
          term_q <= {1'b0, div_rsp.quotient};
          esum_q <= esum_q + 34'(div_rsp.quotient);
          k_q    <= k_q + 4'd1;
        end
      end
      ST_SHIFT: lux_q <= lux_shift;
      ST_FINISH: begin
        if (out_free) begin
          out_avg_q <= avg_q;
          out_pct_q <= pct_q;
          out_lux_q <= lux_q;
          out_sat_q <= sat_q;
          out_cls_q <= cls;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o      = out_valid_q;
  assign average_raw_o    = out_avg_q;
  assign percent_tenths_o = out_pct_q;
  assign lux_estimate_o   = out_lux_q;
  assign lux_saturated_o  = out_sat_q;
  assign light_class_o    = out_cls_q;

endmodule

/* rtl/core/llx_div.sv */
// Iterative restoring divider, one quotient bit per cycle.
// Depends on llx_pkg for widths and the request and response structs.
module llx_div import llx_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  llx_div_req_t req_i,
  output llx_div_rsp_t rsp_o
);

  logic [DVS_W-1:0] rem_q;
  logic [DIV_W-1:0] quo_q;
  logic [DVS_W-1:0] dvs_q;
  logic [5:0]       cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [DVS_W:0]   rem_sh;
  logic             ge;
  logic [DVS_W:0]   rem_sub;

  always_comb begin
    rem_sh  = {rem_q, quo_q[DIV_W-1]};
    ge      = rem_sh >= {1'b0, dvs_q};
    rem_sub = rem_sh - {1'b0, dvs_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 6'd1;
      if (cnt_q == 6'(DIV_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      quo_q <= {quo_q[DIV_W-2:0], ge};
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

/* rtl/core/llx_checker.sv */
// Port-level checks of the lux estimator, bound to its top level.
// Depends on llx_pkg for the class codes.
module llx_checker import llx_pkg::*; #(
  parameter int SAMPLE_BITS = 12
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic [SAMPLE_BITS-1:0] average_raw_o,
  input logic [9:0]             percent_tenths_o,
  input logic [31:0]            lux_estimate_o,
  input logic                   lux_saturated_o,
  input logic [1:0]             light_class_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(lux_estimate_o)
      && $stable(average_raw_o) && $stable(light_class_o))
    else $error("result changed before its transfer");

  a_sat_lux: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && lux_saturated_o |-> lux_estimate_o == 32'hFFFF_FFFF)
    else $error("saturated result without maximum lux");

  a_sat_cls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && lux_saturated_o |-> light_class_o == CLASS_INTENSE)
    else $error("saturated result not in the brightest class");

  a_pct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> percent_tenths_o <= 10'd1000)
    else $error("percent above full scale");

endmodule

bind ldr_lux_estimator llx_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_llx_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .average_raw_o    (average_raw_o),
  .percent_tenths_o (percent_tenths_o),
  .lux_estimate_o   (lux_estimate_o),
  .lux_saturated_o  (lux_saturated_o),
  .light_class_o    (light_class_o)
);

/* tb/sv/tb_ldr_lux_estimator.sv */
// Testbench of the light-sensor lux estimator: random and directed sample streams
// checked against a built-in predictor of averaging and power-law lux estimation.
// Depends on llx_pkg and the ldr_lux_estimator RTL.
module tb_ldr_lux_estimator;
  timeunit 1ns;
  timeprecision 1ps;
  import llx_pkg::*;

  localparam int NSAMP = 8;

  typedef struct {
    logic [11:0] average_raw;
    logic [9:0]  percent_tenths;
    logic [31:0] lux_estimate;
    logic        lux_saturated;
    logic [1:0]  light_class;
  } lux_result_t;

  // Predicts the block's results and holds the results still to come.
  class lux_scoreboard;
    logic [15:0] full_scale;
    logic signed [15:0] weight;
    logic signed [23:0] bias;
    logic [31:0] dim_lim, cozy_lim, bright_lim;
    logic [14:0] sum;
    int unsigned cnt;
    lux_result_t pending[$];
    int errors;

    function new();
      full_scale = 16'd4095;
      weight = 16'sd4096;
      bias = '0;
      dim_lim = 32'd12800;
      cozy_lim = 32'd38400;
      bright_lim = 32'd128000;
      sum = '0;
      cnt = 0;
      errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_FULL_SCALE:   full_scale = val[15:0];
        REG_MODEL_WEIGHT: weight = val[15:0];
        REG_MODEL_BIAS:   bias = val[23:0];
        REG_DIM_LIMIT:    dim_lim = val;
        REG_COZY_LIMIT:   cozy_lim = val;
        REG_BRIGHT_LIMIT: bright_lim = val;
        default: ;
      endcase
    endfunction

    // Arithmetic right shift gives the floor for signed values.
    function longint log2_q20(int unsigned x);
      int unsigned k;
      logic [127:0] m;
      longint frac;
      k = 0;
      frac = 0;
      while (k < 31 && (x >> (k + 1)) != 0) k++;
      m = 128'(x) << (30 - k);
      for (int i = 0; i < 20; i++) begin
        m = (m * m) >> 30;
        frac = frac << 1;
        if (m >= (128'd1 << 31)) begin
          m = m >> 1;
          frac = frac | 1;
        end
      end
      return (longint'(k) << 20) | frac;
    endfunction

    function logic [63:0] exp2_frac(logic [63:0] f);
      logic [127:0] y, term, total;
      y = (128'(f) * 128'(LN2_Q32)) >> 32;
      term = 128'd1 << 32;
      total = term;
      for (int k = 1; k <= 12; k++) begin
        term = ((term * y) >> 32) / k;
        total = total + term;
      end
      return total[63:0];
    endfunction

    function logic [31:0] lux_of(int unsigned fs, int unsigned avg, output logic sat);
      int unsigned r;
      longint lr, e, t, n;
      logic [63:0] p;
      logic [127:0] wide;
      r = (avg > fs - 1) ? fs - 1 : avg;
      sat = 1'b0;
      if (r == 0) begin
        if (weight > 0) begin
          sat = 1'b1;
          return 32'hFFFF_FFFF;
        end
        return 32'd0;
      end
      lr = log2_q20(fs - r) - log2_q20(r);
      e = longint'(weight) * lr + ((longint'(bias) * longint'(LOG2E_Q30)) >>> 14);
      t = e + (longint'(8) <<< 32);
      n = t >>> 32;
      if (n >= 32) begin
        sat = 1'b1;
        return 32'hFFFF_FFFF;
      end
      p = exp2_frac({32'd0, t[31:0]});
      if (n >= 0) begin
        wide = (128'(p) << n) >> 32;
        return wide[31:0];
      end
      if (32 - n >= 64) return 32'd0;
      return 32'(p >> (32 - n));
    endfunction

    // Notes an accepted sample and predicts the result it completes, if any.
    function void note_sample(logic [11:0] s);
      lux_result_t res;
      int unsigned avg, fs, pct;
      sum = sum + 15'(s);
      cnt++;
      if (cnt < NSAMP) return;
      avg = 32'(sum) / NSAMP;
      sum = '0;
      cnt = 0;
      fs = (full_scale < 16'd2) ? 2 : 32'(full_scale);
      pct = (avg * 1000) / fs;
      if (pct > 1000) pct = 1000;
      res.average_raw = 12'(avg);
      res.percent_tenths = 10'(pct);
      res.lux_estimate = lux_of(fs, avg, res.lux_saturated);
      if (res.lux_estimate < dim_lim) res.light_class = CLASS_DARK;
      else if (res.lux_estimate < cozy_lim) res.light_class = CLASS_COZY;
      else if (res.lux_estimate < bright_lim) res.light_class = CLASS_FUNCTIONAL;
      else res.light_class = CLASS_INTENSE;
      pending.push_back(res);
    endfunction

    function void check_result(lux_result_t got);
      lux_result_t want;
      if (pending.size() == 0) begin
        $error("unexpected result transfer: average_raw %0d", got.average_raw);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.average_raw !== want.average_raw) begin
        $error("average_raw expected %0d actual %0d", want.average_raw, got.average_raw);
        errors++;
      end
      if (got.percent_tenths !== want.percent_tenths) begin
        $error("percent_tenths expected %0d actual %0d",
               want.percent_tenths, got.percent_tenths);
        errors++;
      end
      if (got.lux_estimate !== want.lux_estimate) begin
        $error("lux_estimate expected %0h actual %0h", want.lux_estimate, got.lux_estimate);
        errors++;
      end
      if (got.lux_saturated !== want.lux_saturated) begin
        $error("lux_saturated expected %0d actual %0d",
               want.lux_saturated, got.lux_saturated);
        errors++;
      end
      if (got.light_class !== want.light_class) begin
        $error("light_class expected %0d actual %0d", want.light_class, got.light_class);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [11:0] adc_sample_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [11:0] average_raw_o;
  logic [9:0]  percent_tenths_o;
  logic [31:0] lux_estimate_o;
  logic        lux_saturated_o;
  logic [1:0]  light_class_o;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  // Idle percentages of the sender and of the receiver in the current phase.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  lux_scoreboard board = new();

  ldr_lux_estimator dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // The receiver side: ready is redrawn every cycle, and a result transfer is
  // checked at the edge where it happens, sampling the values before the edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      lux_result_t got;
      got.average_raw = average_raw_o;
      got.percent_tenths = percent_tenths_o;
      got.lux_estimate = lux_estimate_o;
      got.lux_saturated = lux_saturated_o;
      got.light_class = light_class_o;
      board.check_result(got);
    end
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Drives one sample and holds it until its transfer, then notes it. Valid stays
  // high after the transfer so that the next sample can follow without a gap; it
  // drops when the sender idles or the stream stops.
  task automatic send_sample(logic [11:0] s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    adc_sample_i <= s;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_sample(s);
  endtask

  // Eight samples around a chosen average with random spread.
  task automatic send_block(int unsigned center, int unsigned spread);
    int lo, hi;
    lo = int'(center) - int'(spread);
    hi = int'(center) + int'(spread);
    if (lo < 0) lo = 0;
    if (hi > 4095) hi = 4095;
    for (int i = 0; i < NSAMP; i++) send_sample(12'($urandom_range(hi, lo)));
  endtask

  // Stops the sample stream and waits for all expected results, plus the tail of
  // a sequence still running.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (700) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    board.set_reg(idx, val);
    cfg_we_i <= 1'b0;
  endtask

  task automatic write_all(logic [15:0] fs, logic [15:0] w, logic [23:0] b,
                           logic [31:0] d, logic [31:0] c, logic [31:0] br);
    write_reg(REG_FULL_SCALE, {16'd0, fs});
    write_reg(REG_MODEL_WEIGHT, {16'd0, w});
    write_reg(REG_MODEL_BIAS, {8'd0, b});
    write_reg(REG_DIM_LIMIT, d);
    write_reg(REG_COZY_LIMIT, c);
    write_reg(REG_BRIGHT_LIMIT, br);
  endtask

  // Random block content, mostly around a random center with some extremes and noise.
  task automatic random_block();
    case ($urandom_range(9))
      0: send_block(0, 3);
      1: send_block(4095, 3);
      2: for (int i = 0; i < NSAMP; i++) send_sample(12'($urandom_range(4095)));
      default: send_block($urandom_range(4095), $urandom_range(200));
    endcase
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: the extremes of the sample, zero raw with both weight signs,
    // an average above full scale and crossed class limits.
    send_sample(12'd0);
    send_sample(12'hFFF);
    send_sample(12'hAAA);
    send_sample(12'h555);
    for (int i = 0; i < 4; i++) send_sample(12'd2048);
    send_block(0, 0);
    send_block(4095, 0);
    drain();
    write_all(16'd1000, 16'hF000, 24'h7FFFFF, 32'd0, 32'hFFFF_FFFF, 32'd5);
    send_block(0, 0);
    send_block(4095, 0);
    drain();
    // Small full scale acts as two; strongest positive weight with the most negative bias.
    write_all(16'd1, 16'h7FFF, 24'h800000, 32'hFFFF_FFFF, 32'd0, 32'd0);
    send_block(1, 0);
    drain();
    write_reg(REG_FULL_SCALE, 32'd0);
    write_reg(REG_MODEL_WEIGHT, 32'h0000_8000);
    send_block(1, 1);
    drain();

    // Random phases under several settings and idling patterns.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase
      case (ph)
        0: write_all(16'd4095, 16'd4096, 24'd0, 32'd12800, 32'd38400, 32'd128000);
        1: write_all(16'd65535, 16'hE000, 24'h0A0000, 32'd100, 32'd10000, 32'd1000000);
        7: write_all(16'd2, 16'd0, 24'hFFFFFF, 32'd256, 32'd512, 32'd1024);
        default: write_all(16'($urandom_range(4200, 2)), 16'($urandom_range(65535)),
                           24'($urandom_range(24'hFFFFFF)), $urandom(), $urandom(),
                           $urandom());
      endcase
      for (int b = 0; b < 9; b++) begin
        random_block();
        // The sender holds off until every result is in, once per phase.
        if (b == 4) begin
          in_valid_i <= 1'b0;
          while (board.pending.size() != 0) @(posedge clk_i);
        end
      end
      drain();
    end

    if (board.errors == 0) $display("ldr_lux_estimator test passed");
    else $display("ldr_lux_estimator test failed");
    $finish;
  end

  initial begin
    #30ms;
    $display("ldr_lux_estimator test failed");
    $finish;
  end
endmodule
